// ----- rtl/mbe_pkg.sv -----
// shared types, constants and round function for the magma block encrypt pipeline
// no dependencies; imported by mbe_key_regs, mbe_round and magma_block_encrypt
`default_nettype none

package mbe_pkg;

  localparam int unsigned NumRounds   = 32;
  localparam int unsigned NumRoundKey = 8;
  localparam int unsigned NumKeyWords = 4;
  localparam int unsigned HalfW       = 32;
  localparam int unsigned BlockW      = 64;
  localparam int unsigned KeyIdxW     = 2;
  localparam int unsigned RotAmt      = 11;

  // configuration register indexes
  typedef enum logic [KeyIdxW-1:0] {
    CFG_KEY_WORD_0 = 2'd0,
    CFG_KEY_WORD_1 = 2'd1,
    CFG_KEY_WORD_2 = 2'd2,
    CFG_KEY_WORD_3 = 2'd3
  } mbe_cfg_idx_e;

  typedef logic [NumRoundKey-1:0][HalfW-1:0] mbe_rkeys_t;

  // one feistel state beat travelling down the pipeline
  typedef struct packed {
    logic             vld;
    logic [HalfW-1:0] left;
    logic [HalfW-1:0] right;
  } mbe_state_t;

  // s-box rows, first row serves the highest nibble
  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
  };

  // round key used by a given round: forward for 24 rounds, then reversed
  function automatic int unsigned rkey_sel(input int unsigned rnd);
    int unsigned sel;
    if (rnd < 24) begin
      sel = rnd % NumRoundKey;
    end else begin
      sel = (NumRounds - 1) - rnd;
    end
    return sel;
  endfunction

  // add key, substitute each nibble, rotate left
  function automatic logic [HalfW-1:0] round_f(input logic [HalfW-1:0] half,
                                               input logic [HalfW-1:0] rk);
    logic [HalfW-1:0] sum;
    logic [HalfW-1:0] sub;
    sum = half + rk;
    for (int k = 0; k < 8; k++) begin
      sub[4*k +: 4] = SBOX[7-k][sum[4*k +: 4]];
    end
    return {sub[HalfW-1-RotAmt:0], sub[HalfW-1:HalfW-RotAmt]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mbe_key_regs.sv -----
// key register file: four 64-bit key words, split into eight round keys
// depends on mbe_pkg
`default_nettype none

module mbe_key_regs (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [mbe_pkg::KeyIdxW-1:0]               cfg_idx_i,
  input  logic [mbe_pkg::BlockW-1:0]                cfg_data_i,
  output mbe_pkg::mbe_rkeys_t                       rkeys_o
);
  import mbe_pkg::*;

  logic [NumKeyWords-1:0][BlockW-1:0] key_q;

  // key word write, all four indexes are in range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        CFG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        CFG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        CFG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // even round key is the high half of its word, odd the low half
  always_comb begin
    for (int j = 0; j < NumKeyWords; j++) begin
      rkeys_o[2*j]   = key_q[j][BlockW-1:HalfW];
      rkeys_o[2*j+1] = key_q[j][HalfW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mbe_round.sv -----
// one feistel round with its pipeline register
// depends on mbe_pkg
`default_nettype none

module mbe_round #(
  parameter bit IsLast = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbe_pkg::mbe_state_t          state_i,
  input  logic [mbe_pkg::HalfW-1:0]    rkey_i,
  output mbe_pkg::mbe_state_t          state_o
);
  import mbe_pkg::*;

  logic [HalfW-1:0] t;
  logic [HalfW-1:0] left_d, right_d;
  logic             vld_q;
  logic [HalfW-1:0] left_q, right_q;

  // round function and half swap, no swap on the last round
  always_comb begin
    t = state_i.left ^ round_f(state_i.right, rkey_i);
    if (IsLast) begin
      left_d  = t;
      right_d = state_i.right;
    end else begin
      left_d  = state_i.right;
      right_d = t;
    end
  end

  // valid bit follows the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= state_i.vld;
    end
  end

  // payload registers, loaded only for a live beat
  always_ff @(posedge clk_i) begin
    if (state_i.vld) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign state_o = '{vld: vld_q, left: left_q, right: right_q};

endmodule

`default_nettype wire

// ----- rtl/magma_block_encrypt.sv -----
// magma 64-bit block encryption, one round per pipeline stage
// the done strobe is the valid bit of the last round's register; throughput one block per cycle
// busy_o never rises, a new block may start on every cycle
// reset clears the stage valid bits and the key words to zero
// depends on mbe_pkg, mbe_key_regs, mbe_round
`default_nettype none

module magma_block_encrypt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [mbe_pkg::BlockW-1:0]       plaintext_i,
  output logic                             done_o,
  output logic [mbe_pkg::BlockW-1:0]       ciphertext_o,
  input  logic                             cfg_we_i,
  input  logic [mbe_pkg::KeyIdxW-1:0]      cfg_idx_i,
  input  logic [mbe_pkg::BlockW-1:0]       cfg_data_i
);
  import mbe_pkg::*;

  mbe_rkeys_t rkeys;
  mbe_state_t stage [NumRounds+1];

  // key storage
  mbe_key_regs u_key_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rkeys_o    (rkeys)
  );

  // pipeline entry
  assign busy_o   = 1'b0;
  assign stage[0] = '{vld: start_i & ~busy_o,
                      left: plaintext_i[BlockW-1:HalfW],
                      right: plaintext_i[HalfW-1:0]};

  // round stages
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    localparam int unsigned KeySel = rkey_sel(r);
    mbe_round #(
      .IsLast (r == NumRounds - 1)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .state_i (stage[r]),
      .rkey_i  (rkeys[KeySel]),
      .state_o (stage[r+1])
    );
  end

  // result beat
  assign done_o       = stage[NumRounds].vld;
  assign ciphertext_o = {stage[NumRounds].left, stage[NumRounds].right};

`ifndef SYNTHESIS
  localparam int unsigned Latency = NumRounds;

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("accepted block did not come out after the pipeline latency");

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("done strobe without a matching start beat");

  a_no_done_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !done_o)
    else $error("done strobe right after reset release");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking bench for magma_block_encrypt: directed table, then random blocks under many keys
// needs rtl/mbe_pkg.sv and the magma_block_encrypt rtl
`timescale 1ns / 100ps

module tb_top;
  import mbe_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned KeyBlocks   = 5;
  localparam int unsigned BlocksPerKey = 70;

  // substitution rows, row 0 serves the top nibble
  localparam logic [0:7][0:15][3:0] Subst = {
    4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
    4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2,
    4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
    4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7,
    4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
    4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0,
    4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
    4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12,
    4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
    4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11,
    4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
    4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0,
    4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
    4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15,
    4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
    4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1
  };

  // one row of the directed table
  typedef struct packed {
    logic              load_key;
    logic [255:0]      key;
    logic [BlockW-1:0] pt;
    logic              chk;
    logic [BlockW-1:0] ct;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [BlockW-1:0] plaintext_i;
  logic              done_o;
  logic [BlockW-1:0] ciphertext_o;
  logic              cfg_we_i;
  logic [KeyIdxW-1:0] cfg_idx_i;
  logic [BlockW-1:0] cfg_data_i;

  // typed expectation travelling with the start beat
  logic              golden_vld;
  logic [BlockW-1:0] golden_ct;

  logic [BlockW-1:0] key_mirror [NumKeyWords];
  logic [BlockW-1:0] pending_ct [$];
  dir_row_t          dir_tab [$];
  int unsigned       mismatch_count;
  int unsigned       stall_cycles;
  int unsigned       gap_pct;

  magma_block_encrypt uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .plaintext_i  (plaintext_i),
    .done_o       (done_o),
    .ciphertext_o (ciphertext_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // round function: key add, nibble substitution, rotate left by 11
  function automatic logic [HalfW-1:0] mix_half(input logic [HalfW-1:0] half,
                                                input logic [HalfW-1:0] rk);
    logic [HalfW-1:0] sum;
    logic [HalfW-1:0] sub;
    sum = half + rk;
    for (int k = 0; k < 8; k++) begin
      sub[4*k +: 4] = Subst[7-k][sum[4*k +: 4]];
    end
    return {sub[20:0], sub[31:21]};
  endfunction

  // full 32-round encipherment under the mirrored key
  function automatic logic [BlockW-1:0] magma_encipher(input logic [BlockW-1:0] blk);
    logic [HalfW-1:0] lh;
    logic [HalfW-1:0] rh;
    logic [HalfW-1:0] t;
    logic [HalfW-1:0] rk;
    int unsigned      sel;
    lh = blk[63:32];
    rh = blk[31:0];
    for (int r = 0; r < 32; r++) begin
      sel = (r < 24) ? (r % 8) : (31 - r);
      rk  = sel[0] ? key_mirror[sel[2:1]][31:0] : key_mirror[sel[2:1]][63:32];
      t   = lh ^ mix_half(rh, rk);
      if (r < 31) begin
        lh = rh;
        rh = t;
      end else begin
        lh = t;
      end
    end
    return {lh, rh};
  endfunction

  // monitor: check result beats, mirror key writes, predict accepted blocks
  always @(posedge clk_i) begin : monitor
    logic [BlockW-1:0] exp_ct;
    logic              moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        moved = 1'b1;
        if (pending_ct.size() == 0) begin
          $display("%0t: unexpected ciphertext beat, expected none, actual %h",
                   $time, ciphertext_o);
          mismatch_count++;
        end else begin
          exp_ct = pending_ct.pop_front();
          if (ciphertext_o !== exp_ct) begin
            $display("%0t: ciphertext mismatch, expected %h, actual %h",
                     $time, exp_ct, ciphertext_o);
            mismatch_count++;
          end
        end
      end
      if (cfg_we_i) begin
        moved = 1'b1;
        key_mirror[cfg_idx_i] = cfg_data_i;
      end
      if (start_i && !busy_o) begin
        moved = 1'b1;
        pending_ct.push_back(golden_vld ? golden_ct : magma_encipher(plaintext_i));
      end
    end
    // watchdog on cycles with no beat at all
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one start beat, with a random gap in front of it
  task automatic send_block(input logic [BlockW-1:0] pt, input logic chk,
                            input logic [BlockW-1:0] ct);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    plaintext_i <= pt;
    golden_vld  <= chk;
    golden_ct   <= ct;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // let every block in flight come out
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_ct.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_key_word(input mbe_cfg_idx_e idx, input logic [BlockW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_key(input logic [255:0] key);
    write_key_word(CFG_KEY_WORD_0, key[255:192]);
    write_key_word(CFG_KEY_WORD_1, key[191:128]);
    write_key_word(CFG_KEY_WORD_2, key[127:64]);
    write_key_word(CFG_KEY_WORD_3, key[63:0]);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    logic [255:0]      rkey;
    logic [BlockW-1:0] pt;
    dir_row_t          row;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    plaintext_i    = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    golden_vld     = 1'b0;
    golden_ct      = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    gap_pct        = 31;
    for (int i = 0; i < NumKeyWords; i++) key_mirror[i] = '0;

    // directed rows: reset key, extreme keys, the published test vector, key ordering
    dir_tab.push_back('{1'b0, 256'h0, 64'h0000000000000000, 1'b0, 64'h0});
    dir_tab.push_back('{1'b0, 256'h0, 64'hffffffffffffffff, 1'b0, 64'h0});
    dir_tab.push_back('{1'b0, 256'h0, 64'h8000000000000000, 1'b0, 64'h0});
    dir_tab.push_back('{1'b0, 256'h0, 64'h0000000000000001, 1'b0, 64'h0});
    dir_tab.push_back('{1'b0, 256'h0, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0});
    dir_tab.push_back('{1'b0, 256'h0, 64'h5555555555555555, 1'b0, 64'h0});
    dir_tab.push_back('{1'b1, {256{1'b1}}, 64'h0000000000000000, 1'b0, 64'h0});
    dir_tab.push_back('{1'b0, {256{1'b1}}, 64'hffffffffffffffff, 1'b0, 64'h0});
    dir_tab.push_back('{1'b0, {256{1'b1}}, 64'h0000000100000001, 1'b0, 64'h0});
    dir_tab.push_back('{1'b1,
      256'hffeeddccbbaa99887766554433221100f0f1f2f3f4f5f6f7f8f9fafbfcfdfeff,
      64'hfedcba9876543210, 1'b1, 64'h4ee901e5c2d8ca3d});
    dir_tab.push_back('{1'b0,
      256'hffeeddccbbaa99887766554433221100f0f1f2f3f4f5f6f7f8f9fafbfcfdfeff,
      64'h0000000000000000, 1'b0, 64'h0});
    dir_tab.push_back('{1'b1,
      256'h0123456789abcdeffedcba98765432100f1e2d3c4b5a69788796a5b4c3d2e1f0,
      64'h0123456789abcdef, 1'b0, 64'h0});
    dir_tab.push_back('{1'b1, {64'hffffffffffffffff, 192'h0},
      64'h0000000000000000, 1'b0, 64'h0});
    dir_tab.push_back('{1'b1, {192'h0, 64'hffffffffffffffff},
      64'h0000000000000000, 1'b0, 64'h0});
    dir_tab.push_back('{1'b1, {64'h0, 64'h00000000ffffffff, 128'h0},
      64'hffffffff00000001, 1'b0, 64'h0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.load_key) begin
        wait_idle();
        set_key(row.key);
      end
      send_block(row.pt, row.chk, row.ct);
    end

    // random part: three idling phases, several keys in each
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 31 : (ph == 1) ? 80 : 0;
      for (int kb = 0; kb < KeyBlocks; kb++) begin
        wait_idle();
        case ($urandom_range(9))
          0: rkey = '0;
          1: rkey = '1;
          default: rkey = {$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom};
        endcase
        set_key(rkey);
        for (int n = 0; n < BlocksPerKey; n++) begin
          case ($urandom_range(15))
            0: pt = '0;
            1: pt = '1;
            2: pt = 64'd1 << $urandom_range(63);
            3: pt = ~(64'd1 << $urandom_range(63));
            default: pt = {$urandom, $urandom};
          endcase
          send_block(pt, 1'b0, '0);
        end
      end
    end

    // drain and report
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mbe_pkg.sv
rtl/mbe_key_regs.sv
rtl/mbe_round.sv
rtl/magma_block_encrypt.sv
sim/tb_top.sv
